[design/cht_pkg.sv]
// Shared constants and codes for the chained hash table engine.
// No dependencies; every other design file but cht_out_if refers to this package by scoped names.
`default_nettype none
package cht_pkg;

  localparam int KEY_W         = 32;
  localparam int CFG_W         = 8;
  localparam int RESET_BUCKETS = 83;

  // The modulo unit retires this many dividend bits per cycle.
  localparam int DIV_BITS      = 4;
  localparam int DIV_STEPS     = KEY_W / DIV_BITS;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

endpackage
`default_nettype wire

[design/cht_in_if.sv]
// Request channel interface: valid/ready handshake carrying action, key and value.
// Uses cht_pkg for the key width.
`default_nettype none
interface cht_in_if #(
  parameter int VALUE_BITS = 64
);
  logic                       valid;
  logic                       ready;
  logic [1:0]                 action;
  logic [cht_pkg::KEY_W-1:0]  key;
  logic [VALUE_BITS-1:0]      value;

  modport source (output valid, action, key, value, input ready);
  modport sink   (input valid, action, key, value, output ready);
endinterface
`default_nettype wire

[design/cht_out_if.sv]
// Result channel interface: valid/ready handshake carrying status, value and count.
// No package dependencies.
`default_nettype none
interface cht_out_if #(
  parameter int VALUE_BITS = 64,
  parameter int COUNT_BITS = 7
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic [VALUE_BITS-1:0] found_value;
  logic [COUNT_BITS-1:0] entry_count;

  modport source (output valid, status, found_value, entry_count, input ready);
  modport sink   (input valid, status, found_value, entry_count, output ready);
endinterface
`default_nettype wire

[design/cht_mod_unit.sv]
// Iterative key modulo bucket-count unit, several dividend bits per cycle.
// Uses cht_pkg for the key width and the digits retired per cycle.
`default_nettype none
module cht_mod_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [cht_pkg::KEY_W-1:0]     dividend,
  input  wire logic [cht_pkg::CFG_W-1:0]     divisor,
  output logic                               done,
  output logic [cht_pkg::CFG_W-1:0]          rem
);
  localparam int CW = (cht_pkg::DIV_STEPS > 1) ? $clog2(cht_pkg::DIV_STEPS) : 1;

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic [cht_pkg::CFG_W-1:0]     rem_r, rem_nxt;
  logic [cht_pkg::KEY_W-1:0]     dvd_r, dvd_nxt;

  always_comb begin
    logic [cht_pkg::CFG_W:0] t;
    logic [cht_pkg::CFG_W-1:0] r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    r        = rem_r;
    t        = '0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvd_nxt  = dividend;
    end else if (busy_r) begin
      // Restoring steps: the partial remainder stays below the divisor.
      for (int i = 0; i < cht_pkg::DIV_BITS; i++) begin
        t = {r, dvd_r[cht_pkg::KEY_W-1-i]};
        if (t >= {1'b0, divisor}) begin
          t = t - {1'b0, divisor};
        end
        r = t[cht_pkg::CFG_W-1:0];
      end
      rem_nxt = r;
      dvd_nxt = dvd_r << cht_pkg::DIV_BITS;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(cht_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;
endmodule
`default_nettype wire

[design/cht_entry_mem.sv]
// Entry pool memory: key, value and link of each slot, one read and one write port.
// Uses cht_pkg for the key width.
`default_nettype none
module cht_entry_mem #(
  parameter int ENTRIES    = 64,
  parameter int VALUE_BITS = 64
) (
  input  wire logic                               clk,
  input  wire logic [$clog2(ENTRIES)-1:0]         rd_addr,
  output logic [cht_pkg::KEY_W-1:0]               rd_key,
  output logic [VALUE_BITS-1:0]                   rd_value,
  output logic [$clog2(ENTRIES+1)-1:0]            rd_link,
  input  wire logic [$clog2(ENTRIES)-1:0]         wr_addr,
  input  wire logic                               wr_data_en,
  input  wire logic                               wr_link_en,
  input  wire logic [cht_pkg::KEY_W-1:0]          wr_key,
  input  wire logic [VALUE_BITS-1:0]              wr_value,
  input  wire logic [$clog2(ENTRIES+1)-1:0]       wr_link
);
  localparam int PW = $clog2(ENTRIES + 1);

  logic [cht_pkg::KEY_W-1:0] keys  [ENTRIES];
  logic [VALUE_BITS-1:0]     vals  [ENTRIES];
  logic [PW-1:0]             links [ENTRIES];

  // Key and value are written together on insert; links are rewritten alone.
  always_ff @(posedge clk) begin
    if (wr_data_en) begin
      keys[wr_addr] <= wr_key;
      vals[wr_addr] <= wr_value;
    end
    if (wr_link_en) begin
      links[wr_addr] <= wr_link;
    end
    rd_key   <= keys[rd_addr];
    rd_value <= vals[rd_addr];
    rd_link  <= links[rd_addr];
  end
endmodule
`default_nettype wire

[design/chained_hash_table_engine.sv]
// Top level of the chained hash table engine: control sequencer and bucket head memory.
// Depends on cht_pkg, cht_in_if, cht_out_if, cht_mod_unit and cht_entry_mem.
`default_nettype none
// The engine keeps up to ENTRIES key/value items in an entry pool, chained per
// bucket, where the bucket is the key modulo the configured bucket count.
// Insert pushes the new entry at the front of its chain (duplicates allowed,
// the newest wins), lookup returns the first match and remove unlinks the
// first match. One item is worked on at a time. An item is accepted, passes
// through the modulo unit (eight digit steps and the registered done), has
// its bucket head read, then is inserted, or for lookup and remove walks its
// chain one entry at a time (plus a step that returns the slot to the free
// list on a remove), and lands in the output register once that is free.
// The walk is bound by the single read port of the entry memory, one entry
// per cycle. Action code 3 does nothing and goes straight to the output
// register. After reset and after every write of the bucket count the bucket
// head memory is swept to empty, one bucket per cycle across all MAX_BUCKETS
// buckets, during which no item is accepted. The output register lets the
// next item be accepted while a result still waits to be taken.
module chained_hash_table_engine #(
  parameter int ENTRIES     = 64,
  parameter int MAX_BUCKETS = 128,
  parameter int VALUE_BITS  = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [cht_pkg::CFG_W-1:0]  cfg_wdata,
  cht_in_if.sink                          in_ch,
  cht_out_if.source                       out_ch
);
  localparam int PW = $clog2(ENTRIES + 1);               // pointer incl. null marker
  localparam int IW = $clog2(ENTRIES);                   // slot index
  localparam int HB = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam logic [PW-1:0] NIL = PW'(ENTRIES);
  localparam int RESET_N = (cht_pkg::RESET_BUCKETS > MAX_BUCKETS) ?
                           MAX_BUCKETS : cht_pkg::RESET_BUCKETS;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_DIV   = 9'b000000100,
    S_HRD   = 9'b000001000,
    S_HEAD  = 9'b000010000,
    S_INS   = 9'b000100000,
    S_WALK  = 9'b001000000,
    S_FREE  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration and table bookkeeping.
  logic [cht_pkg::CFG_W-1:0] nb_r, nb_nxt;
  logic [HB-1:0]             clr_r, clr_nxt;
  logic [PW-1:0]             free_r, free_nxt;
  logic [PW-1:0]             fresh_r, fresh_nxt;   // slots at or above are untouched
  logic [PW-1:0]             count_r, count_nxt;

  // Current item.
  logic [1:0]                act_r, act_nxt;
  logic [cht_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [VALUE_BITS-1:0]     val_r, val_nxt;
  logic [PW-1:0]             cur_r, cur_nxt;
  logic [PW-1:0]             prev_r, prev_nxt;
  logic [PW-1:0]             steps_r, steps_nxt;
  logic [1:0]                res_st_r, res_st_nxt;
  logic [VALUE_BITS-1:0]     res_val_r, res_val_nxt;

  // Output register.
  logic                      ov_r, ov_nxt;
  logic [1:0]                ost_r, ost_nxt;
  logic [VALUE_BITS-1:0]     oval_r, oval_nxt;
  logic [PW-1:0]             ocnt_r, ocnt_nxt;

  // Modulo unit.
  logic                      div_start, div_done;
  logic [cht_pkg::CFG_W-1:0] div_rem;
  logic [HB-1:0]             bucket;

  // Bucket head memory.
  logic [PW-1:0]             heads [MAX_BUCKETS];
  logic [PW-1:0]             head_q;
  logic                      hd_we;
  logic [HB-1:0]             hd_waddr;
  logic [PW-1:0]             hd_wdata;

  // Entry memory ports.
  logic [IW-1:0]             em_raddr, em_waddr;
  logic                      em_data_en, em_link_en;
  logic [PW-1:0]             em_wlink;
  logic [cht_pkg::KEY_W-1:0] em_key;
  logic [VALUE_BITS-1:0]     em_val;
  logic [PW-1:0]             em_link;

  logic in_acc, out_free, cfg_in;
  logic [31:0] cfg_ext;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !ov_r || out_ch.ready;
  assign bucket   = HB'(div_rem);

  // Clamp the written bucket count into 1..MAX_BUCKETS.
  assign cfg_ext = 32'(cfg_wdata);
  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_in = 1'b0;
      nb_nxt = cht_pkg::CFG_W'(1);
    end else if (cfg_ext > 32'(MAX_BUCKETS)) begin
      cfg_in = 1'b0;
      nb_nxt = cht_pkg::CFG_W'(MAX_BUCKETS);
    end else begin
      cfg_in = 1'b1;
      nb_nxt = cfg_wdata;
    end
  end

  cht_mod_unit u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (key_nxt),
    .divisor  (nb_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  cht_entry_mem #(
    .ENTRIES    (ENTRIES),
    .VALUE_BITS (VALUE_BITS)
  ) u_emem (
    .clk        (clk),
    .rd_addr    (em_raddr),
    .rd_key     (em_key),
    .rd_value   (em_val),
    .rd_link    (em_link),
    .wr_addr    (em_waddr),
    .wr_data_en (em_data_en),
    .wr_link_en (em_link_en),
    .wr_key     (key_r),
    .wr_value   (val_r),
    .wr_link    (em_wlink)
  );

  // The head of the current bucket is read every cycle; the address is the
  // held remainder, so head_q is the bucket's head from S_HRD onward.
  always_ff @(posedge clk) begin
    if (hd_we) begin
      heads[hd_waddr] <= hd_wdata;
    end
    head_q <= heads[bucket];
  end

  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    free_nxt    = free_r;
    fresh_nxt   = fresh_r;
    count_nxt   = count_r;
    act_nxt     = act_r;
    key_nxt     = key_r;
    val_nxt     = val_r;
    cur_nxt     = cur_r;
    prev_nxt    = prev_r;
    steps_nxt   = steps_r;
    res_st_nxt  = res_st_r;
    res_val_nxt = res_val_r;
    ov_nxt      = ov_r && !out_ch.ready;
    ost_nxt     = ost_r;
    oval_nxt    = oval_r;
    ocnt_nxt    = ocnt_r;
    div_start   = 1'b0;
    hd_we       = 1'b0;
    hd_waddr    = bucket;
    hd_wdata    = NIL;
    em_raddr    = '0;
    em_waddr    = free_r[IW-1:0];
    em_data_en  = 1'b0;
    em_link_en  = 1'b0;
    em_wlink    = head_q;

    unique case (state_r)
      S_CLEAR: begin
        hd_we    = 1'b1;
        hd_waddr = clr_r;
        hd_wdata = NIL;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == HB'(MAX_BUCKETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          act_nxt     = in_ch.action;
          key_nxt     = in_ch.key;
          val_nxt     = in_ch.value;
          res_st_nxt  = cht_pkg::ST_OK;
          res_val_nxt = '0;
          if (in_ch.action == cht_pkg::ACT_INSERT || in_ch.action == cht_pkg::ACT_LOOKUP
              || in_ch.action == cht_pkg::ACT_REMOVE) begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_HRD;
        end
      end
      S_HRD: begin
        state_nxt = S_HEAD;
      end
      S_HEAD: begin
        if (act_r == cht_pkg::ACT_INSERT) begin
          if (free_r == NIL) begin
            res_st_nxt = cht_pkg::ST_FULL;
            state_nxt  = S_DONE;
          end else begin
            em_raddr  = free_r[IW-1:0];   // if recycled, its link gives the next free slot
            state_nxt = S_INS;
          end
        end else if (head_q >= NIL) begin
          res_st_nxt = cht_pkg::ST_NOT_FOUND;
          state_nxt  = S_DONE;
        end else begin
          em_raddr  = head_q[IW-1:0];
          cur_nxt   = head_q;
          prev_nxt  = NIL;
          steps_nxt = '0;
          state_nxt = S_WALK;
        end
      end
      S_INS: begin
        // An untouched slot links to the next one; a recycled slot holds its link.
        if (free_r == fresh_r) begin
          free_nxt  = fresh_r + 1'b1;
          fresh_nxt = fresh_r + 1'b1;
        end else begin
          free_nxt = em_link;
        end
        em_waddr   = free_r[IW-1:0];
        em_data_en = 1'b1;
        em_link_en = 1'b1;
        em_wlink   = head_q;
        hd_we      = 1'b1;
        hd_wdata   = free_r;
        count_nxt  = count_r + 1'b1;
        state_nxt  = S_DONE;
      end
      S_WALK: begin
        if (em_key == key_r) begin
          res_val_nxt = em_val;
          if (act_r == cht_pkg::ACT_REMOVE) begin
            if (prev_r == NIL) begin
              hd_we    = 1'b1;
              hd_wdata = em_link;
            end else begin
              em_waddr   = prev_r[IW-1:0];
              em_link_en = 1'b1;
              em_wlink   = em_link;
            end
            state_nxt = S_FREE;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (em_link >= NIL || steps_r == PW'(ENTRIES - 1)) begin
          res_st_nxt = cht_pkg::ST_NOT_FOUND;
          state_nxt  = S_DONE;
        end else begin
          em_raddr  = em_link[IW-1:0];
          prev_nxt  = cur_r;
          cur_nxt   = em_link;
          steps_nxt = steps_r + 1'b1;
        end
      end
      S_FREE: begin
        // The removed slot goes back to the front of the free list.
        em_waddr   = cur_r[IW-1:0];
        em_link_en = 1'b1;
        em_wlink   = free_r;
        free_nxt   = cur_r;
        if (count_r != '0) begin
          count_nxt = count_r - 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          ost_nxt   = res_st_r;
          oval_nxt  = (res_st_r == cht_pkg::ST_OK) ? res_val_r : '0;
          ocnt_nxt  = count_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase

    // A bucket count write empties the table, as reset does.
    if (cfg_we) begin
      state_nxt = S_CLEAR;
      clr_nxt   = '0;
      free_nxt  = '0;
      fresh_nxt = '0;
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      free_r  <= '0;
      fresh_r <= '0;
      count_r <= '0;
      nb_r    <= cht_pkg::CFG_W'(RESET_N);
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      free_r  <= free_nxt;
      fresh_r <= fresh_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        nb_r <= cfg_in ? cfg_wdata : nb_nxt;
      end
    end
    act_r     <= act_nxt;
    key_r     <= key_nxt;
    val_r     <= val_nxt;
    cur_r     <= cur_nxt;
    prev_r    <= prev_nxt;
    steps_r   <= steps_nxt;
    res_st_r  <= res_st_nxt;
    res_val_r <= res_val_nxt;
    ost_r     <= ost_nxt;
    oval_r    <= oval_nxt;
    ocnt_r    <= ocnt_nxt;
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = ov_r;
  assign out_ch.status      = ost_r;
  assign out_ch.found_value = oval_r;
  assign out_ch.entry_count = ocnt_r;
endmodule
`default_nettype wire

[design/cht_checker.sv]
// Port-level assertions for the chained hash table engine, bound to the top level.
// Depends on cht_pkg and on chained_hash_table_engine.
`default_nettype none
module cht_checker #(
  parameter int ENTRIES    = 64,
  parameter int VALUE_BITS = 64
) (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          cfg_we,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [1:0]                    out_status,
  input wire logic [VALUE_BITS-1:0]         out_found_value,
  input wire logic [$clog2(ENTRIES+1)-1:0]  out_entry_count
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_found_value) && $stable(out_entry_count))
    else $error("result item changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == cht_pkg::ST_OK || out_status == cht_pkg::ST_NOT_FOUND
      || out_status == cht_pkg::ST_FULL)
    else $error("undefined status code");

  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != cht_pkg::ST_OK |-> out_found_value == '0)
    else $error("value reported on a failed item");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_entry_count) <= 32'(ENTRIES))
    else $error("entry count beyond the pool");

  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("item accepted during the clearing sweep");
endmodule

bind chained_hash_table_engine cht_checker #(
  .ENTRIES    (ENTRIES),
  .VALUE_BITS (VALUE_BITS)
) u_cht_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .cfg_we          (cfg_we),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_found_value (out_ch.found_value),
  .out_entry_count (out_ch.entry_count)
);
`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the chained hash table engine.
// Drives request items through cht_in_if, checks each result against a built-in
// table predictor; depends on cht_pkg, cht_in_if, cht_out_if and the engine.
module testbench;

  localparam int ENTRIES     = 64;
  localparam int MAX_BUCKETS = 128;
  localparam int NIL         = ENTRIES;
  localparam int RAND_ITEMS  = 1566;
  localparam int WATCHDOG    = 20000;
  localparam int SETTLE      = 200;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] found_value;
    logic [6:0]  entry_count;
  } result_t;

  typedef struct {
    logic [1:0]  action;
    logic [31:0] key;
    logic [63:0] value;
    bit          has_known;
    result_t     known;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [cht_pkg::CFG_W-1:0] cfg_wdata;

  cht_in_if  #(.VALUE_BITS(64)) in_ch ();
  cht_out_if #(.VALUE_BITS(64), .COUNT_BITS(7)) out_ch ();

  chained_hash_table_engine #(
    .ENTRIES(ENTRIES), .MAX_BUCKETS(MAX_BUCKETS), .VALUE_BITS(64)
  ) dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // Predicted table contents.
  int unsigned  head_of_bucket[MAX_BUCKETS];
  logic [31:0]  slot_key[ENTRIES];
  logic [63:0]  slot_value[ENTRIES];
  int unsigned  slot_link[ENTRIES];
  int unsigned  free_slot;
  int unsigned  slots_used;
  int unsigned  buckets;

  result_t pending_results[$];
  int      errors;
  int      results_seen;
  int      idle_cycles;
  bit      watchdog_fired;
  logic [31:0] key_pool[8];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void empty_table();
    for (int i = 0; i < MAX_BUCKETS; i++) head_of_bucket[i] = NIL;
    for (int i = 0; i < ENTRIES; i++) begin
      slot_key[i]   = '1;
      slot_value[i] = '0;
      slot_link[i]  = i + 1;
    end
    free_slot  = 0;
    slots_used = 0;
  endfunction

  function automatic result_t apply_request(logic [1:0] act, logic [31:0] k, logic [63:0] v);
    result_t r;
    int unsigned n, b, e, prev, steps;
    bit hit;
    n = buckets;
    if (n == 0) n = 1;
    if (n > MAX_BUCKETS) n = MAX_BUCKETS;
    b = k % n;
    r.status = cht_pkg::ST_OK;
    r.found_value = '0;
    if (act == cht_pkg::ACT_INSERT) begin
      e = free_slot;
      if (e >= ENTRIES) begin
        r.status = cht_pkg::ST_FULL;
      end else begin
        free_slot = slot_link[e];
        slot_key[e] = k;
        slot_value[e] = v;
        slot_link[e] = head_of_bucket[b];
        head_of_bucket[b] = e;
        slots_used++;
      end
    end else if (act == cht_pkg::ACT_LOOKUP || act == cht_pkg::ACT_REMOVE) begin
      prev = NIL;
      e = head_of_bucket[b];
      steps = 0;
      hit = 0;
      while (e < ENTRIES && steps < ENTRIES) begin
        if (slot_key[e] == k) begin
          hit = 1;
          break;
        end
        prev = e;
        e = slot_link[e];
        steps++;
      end
      if (!hit) begin
        r.status = cht_pkg::ST_NOT_FOUND;
      end else begin
        r.found_value = slot_value[e];
        if (act == cht_pkg::ACT_REMOVE) begin
          if (prev == NIL) head_of_bucket[b] = slot_link[e];
          else slot_link[prev] = slot_link[e];
          slot_link[e] = free_slot;
          free_slot = e;
          slot_key[e] = '1;
          slot_value[e] = '0;
          if (slots_used > 0) slots_used--;
        end
      end
    end
    r.entry_count = slots_used[6:0];
    return r;
  endfunction

  // Send one item; waits for acceptance. Predicts at the accepting edge.
  // Valid stays high afterwards; a gap or a drain drops it.
  task automatic send_request(logic [1:0] act, logic [31:0] k, logic [63:0] v,
                              bit has_known, result_t known);
    result_t r;
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.key    <= k;
    in_ch.value  <= v;
    do @(posedge clk); while (!in_ch.ready);
    r = apply_request(act, k, v);
    if (has_known && r != known)
      $error("typed-in expectation disagrees with predictor for key %h", k);
    pending_results.push_back(has_known ? known : r);
  endtask

  // Random gap between bursts; valid drops only when there is a gap.
  task automatic sender_gap();
    int g;
    g = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0 && !watchdog_fired) @(posedge clk);
    // An action-3 item is already answered when it leaves, so a short pause suffices.
    repeat (20) @(posedge clk);
  endtask

  task automatic write_bucket_count(logic [7:0] n);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we    <= 1'b0;
    buckets = n;
    empty_table();
  endtask

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'hFFFF_FFFF;
      default: return key_pool[$urandom_range(0, 7)];
    endcase
  endfunction

  function automatic logic [1:0] pick_action();
    int w;
    w = $urandom_range(0, 99);
    if (w < 40) return cht_pkg::ACT_INSERT;
    if (w < 70) return cht_pkg::ACT_LOOKUP;
    if (w < 97) return cht_pkg::ACT_REMOVE;
    return 2'd3;
  endfunction

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Receiver: stalls on its own pattern and checks each item against the oldest expectation.
  int stall_phase;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_phase  <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      if ((stall_phase / 256) % 3 == 2) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(0, 99) < 65);
      if (out_ch.valid && out_ch.ready) begin
        results_seen <= results_seen + 1;
        if (pending_results.size() == 0) begin
          $error("result arrived with none expected");
          errors = errors + 1;
        end else begin
          result_t x;
          x = pending_results.pop_front();
          if (out_ch.status !== x.status) begin
            $error("status: expected %0d, got %0d", x.status, out_ch.status);
            errors = errors + 1;
          end
          if (out_ch.found_value !== x.found_value) begin
            $error("found_value: expected %h, got %h", x.found_value, out_ch.found_value);
            errors = errors + 1;
          end
          if (out_ch.entry_count !== x.entry_count) begin
            $error("entry_count: expected %0d, got %0d", x.entry_count, out_ch.entry_count);
            errors = errors + 1;
          end
        end
      end
    end
  end

  // Watchdog counts cycles without any accepted item on either channel or a bucket count write.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG && !watchdog_fired) begin
      watchdog_fired = 1;
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic stim_row_t row(logic [1:0] a, logic [31:0] k, logic [63:0] v,
                                    bit hk, logic [1:0] s, logic [63:0] f, logic [6:0] c);
    stim_row_t t;
    t.action = a; t.key = k; t.value = v; t.has_known = hk;
    t.known.status = s; t.known.found_value = f; t.known.entry_count = c;
    return t;
  endfunction

  stim_row_t directed[$];

  initial begin
    int sent;
    int phase_len;
    logic [7:0] settings[6];
    errors = 0; results_seen = 0; idle_cycles = 0; watchdog_fired = 0;
    rst_n = 1'b0; cfg_we = 1'b0; cfg_wdata = '0;
    in_ch.valid = 1'b0; in_ch.action = cht_pkg::ACT_INSERT; in_ch.key = '0;
    in_ch.value = '0;
    out_ch.ready = 1'b0;
    buckets = cht_pkg::RESET_BUCKETS;
    empty_table();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows: rows with typed-in results follow the table from reset.
    directed.push_back(row(cht_pkg::ACT_LOOKUP, 32'd5, '0, 1, cht_pkg::ST_NOT_FOUND,
                           '0, 7'd0));
    directed.push_back(row(cht_pkg::ACT_REMOVE, 32'd5, '0, 1, cht_pkg::ST_NOT_FOUND,
                           '0, 7'd0));
    directed.push_back(row(cht_pkg::ACT_INSERT, 32'd0, '1, 1, cht_pkg::ST_OK, '0, 7'd1));
    directed.push_back(row(cht_pkg::ACT_LOOKUP, 32'd0, '0, 1, cht_pkg::ST_OK, '1, 7'd1));
    directed.push_back(row(cht_pkg::ACT_INSERT, 32'hFFFF_FFFF, 64'h1, 1, cht_pkg::ST_OK,
                           '0, 7'd2));
    directed.push_back(row(cht_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, '0, 1, cht_pkg::ST_OK,
                           64'h1, 7'd2));
    directed.push_back(row(cht_pkg::ACT_INSERT, 32'hFFFF_FFFE, '0, 0, 0, 0, 0));
    directed.push_back(row(cht_pkg::ACT_INSERT, 32'd83, 64'hAAAA_5555_AAAA_5555,
                           0, 0, 0, 0));
    directed.push_back(row(cht_pkg::ACT_INSERT, 32'd0, 64'h2, 0, 0, 0, 0));
    directed.push_back(row(cht_pkg::ACT_LOOKUP, 32'd0, '0, 0, 0, 0, 0));
    directed.push_back(row(cht_pkg::ACT_REMOVE, 32'd0, '0, 0, 0, 0, 0));
    directed.push_back(row(cht_pkg::ACT_LOOKUP, 32'd0, '0, 0, 0, 0, 0));
    directed.push_back(row(cht_pkg::ACT_REMOVE, 32'd83, '0, 0, 0, 0, 0));
    directed.push_back(row(2'd3, 32'd83, '1, 0, 0, 0, 0));
    directed.push_back(row(cht_pkg::ACT_LOOKUP, 32'hFFFF_FFFE, '0, 0, 0, 0, 0));
    foreach (directed[i]) begin
      send_request(directed[i].action, directed[i].key, directed[i].value,
                   directed[i].has_known, directed[i].known);
      sender_gap();
    end

    // Fill to the limit with one bucket so the full status and long chains show up.
    write_bucket_count(8'd1);
    for (int i = 0; i < ENTRIES + 2; i++) begin
      result_t none;
      send_request(cht_pkg::ACT_INSERT, $urandom(), {$urandom(), $urandom()}, 0, none);
    end
    begin
      result_t none;
      send_request(cht_pkg::ACT_LOOKUP, 32'h1234_5678, '0, 0, none);
    end

    // Random phases across several bucket counts, including out-of-range writes.
    settings = '{8'd0, 8'd128, 8'd255, 8'd3, 8'd83, 8'd17};
    sent = 0;
    foreach (settings[p]) begin
      write_bucket_count(settings[p]);
      foreach (key_pool[i]) key_pool[i] = $urandom_range(0, 300) + (i == 7 ? 32'hFFFF_FF00 : 0);
      phase_len = RAND_ITEMS / 6;
      for (int i = 0; i < phase_len; i++) begin
        result_t none;
        send_request(pick_action(), pick_key(), pick_value(), 0, none);
        sent++;
        if (i == phase_len / 2) drain_results();
        else if ($urandom_range(0, 5) == 0) sender_gap();
      end
    end

    drain_results();
    repeat (SETTLE) @(posedge clk);
    $display("Covered %0d random requests over six bucket settings plus directed rows;",
             sent);
    $display("%0d results were checked against the table predictor.", results_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
